### rtl/vsa_pkg.sv
// ----------------------------------------------------------------------------
// vsa_pkg
// types and codes shared by the voice slot allocator
// ----------------------------------------------------------------------------
package vsa_pkg;

    localparam int SLOT_W  = 6;
    localparam int AUDIO_W = 16;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [SLOT_W-1:0]  slot;
        logic [AUDIO_W-1:0] audio_id;
    } t_cmd_word;

    typedef struct packed {
        logic [1:0]         status;
        logic [SLOT_W-1:0]  slot_out;
        logic [AUDIO_W-1:0] audio_out;
        logic               table_full;
    } t_rsp_word;

endpackage

### rtl/vsa_audio_ram.sv
// ----------------------------------------------------------------------------
// vsa_audio_ram
// audio id store, one write and one registered read port
// ----------------------------------------------------------------------------
module vsa_audio_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/voice_slot_allocator_top.sv
// ----------------------------------------------------------------------------
// voice_slot_allocator_top
// voice slot table with valid bits, stored audio ids and a next-free hint
// ----------------------------------------------------------------------------
// free, lookup and most allocates go from IDLE through EXEC and DONE, and the result
// is registered out of DONE; an allocate that takes a slot and whose following slot is
// taken or missing scans the valid bits in SCAN first, from slot 0, one slot a cycle.
// a new command is taken in the cycle its predecessor's result shows, not before
// the result strobe lasts one cycle; the receiver cannot stall
// reset (synchronous, active low) frees every slot and zeroes the hint, not the audio store
module voice_slot_allocator_top #(
    parameter int NUM_SLOTS     = 64,
    parameter int AUDIO_ID_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  vsa_pkg::t_cmd_word i_cmd,
    output logic              o_rsp_valid,
    output vsa_pkg::t_rsp_word o_rsp
);

    import vsa_pkg::*;

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int UW = SW + 1;
    localparam int CW = ((SW > SLOT_W) ? SW : SLOT_W) + 1;
    localparam int AW = (AUDIO_ID_BITS < AUDIO_W) ? AUDIO_ID_BITS : AUDIO_W;

    t_state r_state, n_state;

    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [UW-1:0]        r_used, n_used;
    logic [SW-1:0]        r_hint, n_hint;
    logic [SW-1:0]        r_idx, n_idx;

    t_cmd_word            r_cmd, n_cmd;
    logic [1:0]           r_status, n_status;
    logic [SLOT_W-1:0]    r_sout, n_sout;
    logic [AUDIO_W-1:0]   r_aout, n_aout;
    logic                 r_use_mem, n_use_mem;

    t_rsp_word            r_rsp, n_rsp;
    logic                 r_rsp_valid, n_rsp_valid;

    logic                 ram_we;
    logic [AW-1:0]        ram_rdata;
    logic [AW-1:0]        aid_st;
    logic [SW-1:0]        slot_idx;
    logic [SW-1:0]        hint_inc;
    logic                 slot_in_range;
    logic                 alloc_busy;
    logic                 nxt_free;
    logic                 slot_ok;
    logic                 scan_hit;
    logic                 scan_last;

    assign aid_st        = AW'(r_cmd.audio_id);
    assign slot_idx      = SW'(r_cmd.slot);
    assign hint_inc      = r_hint + SW'(1);
    assign slot_in_range = CW'(r_cmd.slot) < CW'(NUM_SLOTS);
    assign alloc_busy    = r_valid[r_hint];
    // following slot must exist and be free to skip the scan
    assign nxt_free      = ((CW'(r_hint) + CW'(1)) < CW'(NUM_SLOTS)) && !r_valid[hint_inc];
    assign slot_ok       = slot_in_range && r_valid[slot_idx];
    assign scan_hit      = !r_valid[r_idx];
    assign scan_last     = r_idx == SW'(NUM_SLOTS - 1);

    vsa_audio_ram #(
        .DEPTH  (NUM_SLOTS),
        .WIDTH  (AW),
        .ADDR_W (SW)
    ) u_audio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_hint),
        .i_wdata (aid_st),
        .i_raddr (slot_idx),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (r_cmd.opcode == OP_ALLOC && !alloc_busy && !nxt_free) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_hit || scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_valid     = r_valid;
        n_used      = r_used;
        n_hint      = r_hint;
        n_idx       = r_idx;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_sout      = r_sout;
        n_aout      = r_aout;
        n_use_mem   = r_use_mem;
        n_rsp       = r_rsp;
        n_rsp_valid = 1'b0;
        ram_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                end
            end
            S_EXEC: begin
                n_use_mem = 1'b0;
                n_status  = ST_OK;
                n_sout    = '0;
                n_aout    = '0;
                unique case (r_cmd.opcode) inside
                    OP_ALLOC: begin
                        if (alloc_busy) begin
                            n_status = ST_FULL;
                        end else begin
                            n_valid[r_hint] = 1'b1;
                            ram_we          = 1'b1;
                            n_used          = r_used + UW'(1);
                            n_sout          = SLOT_W'(r_hint);
                            n_aout          = AUDIO_W'(aid_st);
                            if (nxt_free) begin
                                n_hint = hint_inc;
                            end else begin
                                n_idx = '0;
                            end
                        end
                    end
                    OP_FREE, OP_LOOKUP: begin
                        n_sout = r_cmd.slot;
                        if (!slot_ok) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_use_mem = 1'b1;
                            if (r_cmd.opcode == OP_FREE) begin
                                n_valid[slot_idx] = 1'b0;
                                n_used            = r_used - UW'(1);
                                n_hint            = slot_idx;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                // slot just taken is already marked, so any clear bit will do
                if (scan_hit) begin
                    n_hint = r_idx;
                end else if (!scan_last) begin
                    n_idx = r_idx + SW'(1);
                end
            end
            S_DONE: begin
                n_rsp.status     = r_status;
                n_rsp.slot_out   = r_sout;
                n_rsp.audio_out  = r_use_mem ? AUDIO_W'(ram_rdata) : r_aout;
                n_rsp.table_full = r_used == UW'(NUM_SLOTS);
                n_rsp_valid      = 1'b1;
            end
            default: begin
                n_rsp_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_hint      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_used      <= n_used;
            r_hint      <= n_hint;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_sout    <= n_sout;
        r_aout    <= n_aout;
        r_use_mem <= n_use_mem;
        r_rsp     <= n_rsp;
    end

    assign busy        = r_state != S_IDLE;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("slot count out of step with valid bits");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |=> !o_rsp_valid)
        else $error("result strobe longer than one cycle");

    a_start_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_state == S_EXEC)
        else $error("accepted command not executed");

    a_scan_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> r_valid[r_hint])
        else $error("scan running with hinted slot free");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == ST_FULL) |-> o_rsp.table_full)
        else $error("allocate rejected while table not full");

endmodule

### verif/tb_voice_slot_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voice_slot_allocator_top
// self-checking bench for the voice slot allocator
// ----------------------------------------------------------------------------
// a short table of directed commands, some with the reply typed in, then
// random episodes of filling, draining and mixed traffic. every accepted
// command is run through a slot table kept in the bench, and each reply word
// is checked against the oldest predicted one. the sender idles in bursts.
// ----------------------------------------------------------------------------
module tb_voice_slot_allocator_top;
    import vsa_pkg::*;

    localparam int         NUM_SLOTS  = 64;
    localparam int         RAND_WORDS = 1700;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    typedef struct {
        t_cmd_word cmd;
        bit        typed;
        t_rsp_word want;
    } t_stim_row;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic       busy;
    t_cmd_word  i_cmd   = '0;
    logic       o_rsp_valid;
    t_rsp_word  o_rsp;

    // slot table as the bench sees it
    bit                 slot_used [NUM_SLOTS];
    logic [AUDIO_W-1:0] slot_clip [NUM_SLOTS];
    int unsigned        hint_slot;

    t_rsp_word pending_rsp [$];
    t_stim_row stim_rows [$];
    int        n_faults     = 0;
    int        n_refused    = 0;
    int        n_empty      = 0;
    int        n_full_seen  = 0;
    int        n_sent       = 0;
    int        burst_left   = 0;

    voice_slot_allocator_top #(
        .NUM_SLOTS     (NUM_SLOTS),
        .AUDIO_ID_BITS (AUDIO_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    task automatic log_fault(input string what);
        if (n_faults < 10) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        n_faults++;
    endtask

    function automatic int free_slots();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_used[i]) begin
                n++;
            end
        end
        return n;
    endfunction

    // allocate, free or look up in the bench table and give the reply word
    function automatic t_rsp_word apply_cmd(input t_cmd_word c);
        t_rsp_word   r;
        int unsigned taken;
        int unsigned nxt;
        bit          found;
        r        = '0;
        r.status = ST_OK;
        case (c.opcode) inside
            OP_ALLOC: begin
                taken = hint_slot;
                if (slot_used[taken]) begin
                    r.status = ST_FULL;
                end else begin
                    slot_used[taken] = 1'b1;
                    slot_clip[taken] = c.audio_id;
                    r.slot_out       = SLOT_W'(taken);
                    r.audio_out      = c.audio_id;
                    nxt              = taken + 1;
                    if (nxt < NUM_SLOTS && !slot_used[nxt]) begin
                        hint_slot = nxt;
                    end else begin
                        // lowest free slot; hint stays put when none is left
                        found = 1'b0;
                        for (int i = 0; i < NUM_SLOTS; i++) begin
                            if (!found && i != taken && !slot_used[i]) begin
                                hint_slot = i;
                                found     = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_FREE, OP_LOOKUP: begin
                r.slot_out = c.slot;
                if (!slot_used[c.slot]) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.audio_out = slot_clip[c.slot];
                    if (c.opcode == OP_FREE) begin
                        slot_used[c.slot] = 1'b0;
                        hint_slot         = 32'(c.slot);
                    end
                end
            end
            default: ;
        endcase
        r.table_full = (free_slots() == 0);
        return r;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_used_slot();
        int base;
        base = $urandom_range(0, NUM_SLOTS - 1);
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (slot_used[(base + k) % NUM_SLOTS]) begin
                return SLOT_W'((base + k) % NUM_SLOTS);
            end
        end
        return SLOT_W'(base);
    endfunction

    function automatic t_cmd_word make_cmd(input logic [1:0] op, input bit aim_used);
        t_cmd_word c;
        c.opcode = op;
        c.slot   = aim_used ? pick_used_slot() : SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        case ($urandom_range(0, 9))
            0:       c.audio_id = '0;
            1:       c.audio_id = '1;
            default: c.audio_id = AUDIO_W'($urandom_range(0, 65535));
        endcase
        return c;
    endfunction

    task automatic add_row(input t_cmd_word c, input bit typed, input t_rsp_word w);
        t_stim_row row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = w;
        stim_rows.push_back(row);
    endtask

    // send one command word, idling in bursts, and predict its reply
    task automatic issue(input t_cmd_word c, input bit typed, input t_rsp_word want);
        t_rsp_word model;
        int        gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        burst_left--;
        n_sent++;
        model = apply_cmd(c);
        pending_rsp.push_back(typed ? want : model);
        if (model.status == ST_FULL) n_refused++;
        if (model.status == ST_EMPTY) n_empty++;
        if (model.table_full) n_full_seen++;
    endtask

    task automatic wait_settled();
        start      <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_rsp.size() != 0);
    endtask

    task automatic run_random(input logic [1:0] op, input bit aim_used);
        issue(make_cmd(op, aim_used), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : check_rsp
        t_rsp_word want;
        if (i_rst_n && o_rsp_valid !== 1'b0) begin
            if (pending_rsp.size() == 0) begin
                log_fault($sformatf("reply word with nothing pending: %h", o_rsp));
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status || o_rsp.slot_out !== want.slot_out ||
                    o_rsp.audio_out !== want.audio_out ||
                    o_rsp.table_full !== want.table_full) begin
                    // fields in order: status, slot, audio id, table full
                    log_fault($sformatf("exp %0d/%0d/%h/%0d, got %0d/%0d/%h/%0d",
                        want.status, want.slot_out, want.audio_out, want.table_full,
                        o_rsp.status, o_rsp.slot_out, o_rsp.audio_out, o_rsp.table_full));
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("timeout waiting on the allocator");
        $display("Test completed with failures");
        $finish;
    end

    initial begin : drive
        int n_random;
        int pick;
        int reps;
        int w;

        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_clip[i] = '0;
        end
        hint_slot = 0;

        // fresh table: empty replies, unused opcode, ignored slot on allocate
        add_row({OP_LOOKUP, 6'd0, 16'h0000},  1, {ST_EMPTY, 6'd0, 16'h0000, 1'b0});
        add_row({OP_LOOKUP, 6'd63, 16'hffff}, 1, {ST_EMPTY, 6'd63, 16'h0000, 1'b0});
        add_row({OP_FREE, 6'd63, 16'h0000},   1, {ST_EMPTY, 6'd63, 16'h0000, 1'b0});
        add_row({OP_UNUSED, 6'd63, 16'hffff}, 1, {ST_OK, 6'd0, 16'h0000, 1'b0});
        add_row({OP_ALLOC, 6'd63, 16'hffff},  1, {ST_OK, 6'd0, 16'hffff, 1'b0});
        add_row({OP_ALLOC, 6'd0, 16'h0000},   1, {ST_OK, 6'd1, 16'h0000, 1'b0});
        add_row({OP_ALLOC, 6'd21, 16'h8001},  0, '0);
        add_row({OP_LOOKUP, 6'd0, 16'h0000},  1, {ST_OK, 6'd0, 16'hffff, 1'b0});
        add_row({OP_LOOKUP, 6'd1, 16'h7fff},  0, '0);
        add_row({OP_FREE, 6'd0, 16'h0000},    1, {ST_OK, 6'd0, 16'hffff, 1'b0});
        add_row({OP_LOOKUP, 6'd0, 16'h0000},  1, {ST_EMPTY, 6'd0, 16'h0000, 1'b0});
        // hint back on slot 0 with slot 1 taken, so the next hint comes from a scan
        add_row({OP_ALLOC, 6'd42, 16'h1234},  0, '0);
        add_row({OP_ALLOC, 6'd0, 16'h5555},   0, '0);
        add_row({OP_FREE, 6'd2, 16'h0000},    0, '0);
        add_row({OP_ALLOC, 6'd0, 16'haaaa},   0, '0);
        add_row({OP_FREE, 6'd1, 16'h0000},    0, '0);
        add_row({OP_FREE, 6'd3, 16'h0000},    0, '0);
        add_row({OP_LOOKUP, 6'd3, 16'h0000},  0, '0);
        add_row({OP_UNUSED, 6'd42, 16'h5a5a}, 0, '0);
        add_row({OP_LOOKUP, 6'd2, 16'h0000},  0, '0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[k]) begin
            issue(stim_rows[k].cmd, stim_rows[k].typed, stim_rows[k].want);
        end
        wait_settled();

        n_random = 0;
        while (n_random < RAND_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                // fill the table, then knock on it while full
                while (free_slots() != 0) begin
                    if ($urandom_range(0, 9) == 0) run_random(OP_LOOKUP, 1'b1);
                    else run_random(OP_ALLOC, 1'b0);
                    n_random++;
                end
                reps = $urandom_range(1, 3);
                repeat (reps) begin
                    run_random(OP_ALLOC, 1'b0);
                    n_random++;
                end
            end else if (pick < 45 && free_slots() != NUM_SLOTS) begin
                reps = $urandom_range(1, NUM_SLOTS - free_slots());
                repeat (reps) begin
                    if ($urandom_range(0, 9) == 0) run_random(OP_LOOKUP, 1'b1);
                    else run_random(OP_FREE, $urandom_range(0, 4) != 0);
                    n_random++;
                end
            end else begin
                reps = $urandom_range(20, 80);
                repeat (reps) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40) run_random(OP_ALLOC, 1'b0);
                    else if (pick < 70) run_random(OP_FREE, $urandom_range(0, 4) != 0);
                    else if (pick < 93) run_random(OP_LOOKUP, $urandom_range(0, 4) != 0);
                    else run_random(OP_UNUSED, 1'b0);
                    n_random++;
                end
                if ($urandom_range(0, 3) == 0) wait_settled();
            end
        end
        start <= 1'b0;

        for (w = 0; w < 20000 && pending_rsp.size() != 0; w++) @(posedge i_clk);
        // an allocate scan can run the whole table
        repeat (NUM_SLOTS + 8) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            log_fault($sformatf("%0d reply words never arrived", pending_rsp.size()));
        end

        $display("%0d command words sent, %0d allocates refused on a full table,",
                 n_sent, n_refused);
        $display("%0d empty-slot replies, %0d replies with the table full, %0d faults",
                 n_empty, n_full_seen, n_faults);
        if (n_faults == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
